// ===== rtl/bracket_nesting_checker_macros.svh =====
// Assertion macros for the bracket nesting checker.
// Expect clk and rst_n in the scope of the module that expands them.
`ifndef BRACKET_NESTING_CHECKER_MACROS_SVH
`define BRACKET_NESTING_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BNC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BNC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bnc_pkg.sv =====
// Shared types, codes and constants of the bracket nesting checker.
// No dependencies; used by every module of the block.
package bnc_pkg;

    localparam int WEIGHT_W    = 16;
    localparam int SCORE_W     = 64;
    localparam int TOTAL_W     = 48;
    localparam int CFG_INDEX_W = 2;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          line_status;
        logic [WEIGHT_W-1:0] line_points;
        logic [SCORE_W-1:0]  completion_score;
        logic [TOTAL_W-1:0]  error_total;
    } out_item_t;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_ROUND  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SQUARE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_CURLY  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_ANGLE  = 2'd3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ROUND_RST  = 16'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SQUARE_RST = 16'd57;
    localparam logic [WEIGHT_W-1:0] WEIGHT_CURLY_RST  = 16'd1197;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ANGLE_RST  = 16'd25137;

    localparam logic [1:0] FAIL_NONE     = 2'd0;
    localparam logic [1:0] FAIL_CORRUPT  = 2'd2;
    localparam logic [1:0] FAIL_OVERFLOW = 2'd3;

    localparam logic [1:0] LINE_BALANCED   = 2'd0;
    localparam logic [1:0] LINE_INCOMPLETE = 2'd1;

    localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;
    localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_ANGLE_OPEN   = 8'h3C;
    localparam logic [7:0] CH_ANGLE_CLOSE  = 8'h3E;

    localparam logic [2:0] SCORE_BASE_SHIFT = 3'd2;

    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
    } char_class_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic check;
        logic fail_overflow;
        logic fail_corrupt;
        logic eol_start;
        logic walk_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_eol;
        logic is_open;
        logic is_close;
        logic line_clean;
        logic depth_zero;
        logic depth_full;
        logic walk_last;
        logic out_busy;
    } dp_status_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r = '0;
        case (c)
            CH_ROUND_OPEN:   begin r.is_open  = 1'b1; r.kind = KIND_ROUND;  end
            CH_SQUARE_OPEN:  begin r.is_open  = 1'b1; r.kind = KIND_SQUARE; end
            CH_CURLY_OPEN:   begin r.is_open  = 1'b1; r.kind = KIND_CURLY;  end
            CH_ANGLE_OPEN:   begin r.is_open  = 1'b1; r.kind = KIND_ANGLE;  end
            CH_ROUND_CLOSE:  begin r.is_close = 1'b1; r.kind = KIND_ROUND;  end
            CH_SQUARE_CLOSE: begin r.is_close = 1'b1; r.kind = KIND_SQUARE; end
            CH_CURLY_CLOSE:  begin r.is_close = 1'b1; r.kind = KIND_CURLY;  end
            CH_ANGLE_CLOSE:  begin r.is_close = 1'b1; r.kind = KIND_ANGLE;  end
            default:         r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bnc_ctrl.sv =====
// Controller state machine of the bracket nesting checker.
// Depends on bnc_pkg and bracket_nesting_checker_macros.svh.
`include "bracket_nesting_checker_macros.svh"

module bnc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bnc_pkg::dp_status_t st,
    output bnc_pkg::dp_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.is_eol)
                    begin
                        cmd.eol_start = 1'b1;
                        state_next    = (st.line_clean && !st.depth_zero) ? S_WALK : S_FIN;
                    end
                    else if (st.line_clean)
                    begin
                        if (st.is_open)
                        begin
                            if (st.depth_full)
                                cmd.fail_overflow = 1'b1;
                            else
                                cmd.push = 1'b1;
                        end
                        else if (st.is_close)
                        begin
                            if (st.depth_zero)
                                cmd.fail_corrupt = 1'b1;
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        else
                            cmd.fail_corrupt = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                cmd.check  = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (st.walk_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `BNC_ASSERT_NEXT(a_pop_then_check, cmd.pop, cmd.check, "pop not followed by compare")
    `BNC_ASSERT_NOW(a_idle_no_work, in_ready, !cmd.check && !cmd.walk_step && !cmd.finish, "work issued while taking input")

endmodule

// ===== rtl/bnc_datapath.sv =====
// Datapath of the bracket nesting checker: stack memory, line state,
// score walk, running total and output register. Depends on bnc_pkg.
`include "bracket_nesting_checker_macros.svh"

module bnc_datapath #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bnc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bnc_pkg::WEIGHT_W-1:0]        cfg_data,
    input  bnc_pkg::in_item_t                   in_data,
    input  bnc_pkg::dp_cmd_t                    cmd,
    output bnc_pkg::dp_status_t                 st,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bnc_pkg::out_item_t                  out_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

    logic [1:0]                     stack_mem [STACK_DEPTH];
    logic [1:0]                     rd_data_reg;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;

    logic [bnc_pkg::WEIGHT_W-1:0]   weight_reg [4];
    logic [DW-1:0]                  depth_reg, depth_next, depth_dec;
    logic [1:0]                     fail_reg, fail_next;
    logic [bnc_pkg::WEIGHT_W-1:0]   fail_pts_reg, fail_pts_next;
    logic [bnc_pkg::TOTAL_W-1:0]    total_reg, total_next, total_sat;
    logic [bnc_pkg::TOTAL_W:0]      total_sum;
    logic                           out_valid_reg, out_valid_next;

    logic [bnc_pkg::SCORE_W-1:0]    score_reg, score_step;
    logic [AW-1:0]                  idx_reg;
    logic [1:0]                     kind_reg;
    bnc_pkg::out_item_t             out_reg, out_next;
    bnc_pkg::char_class_t           cls;

    assign cls       = bnc_pkg::classify(in_data.char_code);
    assign depth_dec = depth_reg - DW'(1);

    assign st.is_eol     = (in_data.operation == bnc_pkg::OP_EOL);
    assign st.is_open    = cls.is_open;
    assign st.is_close   = cls.is_close;
    assign st.line_clean = (fail_reg == bnc_pkg::FAIL_NONE);
    assign st.depth_zero = (depth_reg == '0);
    assign st.depth_full = (depth_reg == DEPTH_MAX);
    assign st.walk_last  = (idx_reg == '0);
    assign st.out_busy   = out_valid_reg && !out_ready;

    assign rd_en = cmd.pop || (cmd.eol_start && !st.depth_zero)
                 || (cmd.walk_step && !st.walk_last);
    assign rd_addr = cmd.walk_step ? (idx_reg - AW'(1)) : depth_dec[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[depth_reg[AW-1:0]] <= cls.kind;
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    assign score_step = (score_reg << bnc_pkg::SCORE_BASE_SHIFT) + score_reg
                      + bnc_pkg::SCORE_W'(rd_data_reg) + bnc_pkg::SCORE_W'(1);

    assign total_sum = {1'b0, total_reg} + (bnc_pkg::TOTAL_W + 1)'(fail_pts_reg);
    assign total_sat = total_sum[bnc_pkg::TOTAL_W] ? '1 : total_sum[bnc_pkg::TOTAL_W-1:0];

    always_comb
    begin
        out_next.line_status      = (fail_reg != bnc_pkg::FAIL_NONE) ? fail_reg
                                  : (st.depth_zero ? bnc_pkg::LINE_BALANCED
                                                   : bnc_pkg::LINE_INCOMPLETE);
        out_next.line_points      = fail_pts_reg;
        out_next.completion_score = score_reg;
        out_next.error_total      = total_sat;
    end

    always_comb
    begin
        depth_next     = depth_reg;
        fail_next      = fail_reg;
        fail_pts_next  = fail_pts_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.push)
            depth_next = depth_reg + DW'(1);
        if (cmd.pop)
            depth_next = depth_dec;
        if (cmd.fail_overflow)
        begin
            fail_next     = bnc_pkg::FAIL_OVERFLOW;
            fail_pts_next = '0;
        end
        if (cmd.fail_corrupt)
        begin
            fail_next     = bnc_pkg::FAIL_CORRUPT;
            fail_pts_next = '0;
        end
        if (cmd.check && (rd_data_reg != kind_reg))
        begin
            fail_next     = bnc_pkg::FAIL_CORRUPT;
            fail_pts_next = weight_reg[kind_reg];
        end
        if (cmd.finish)
        begin
            total_next     = total_sat;
            depth_next     = '0;
            fail_next      = bnc_pkg::FAIL_NONE;
            fail_pts_next  = '0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            fail_reg      <= bnc_pkg::FAIL_NONE;
            fail_pts_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            weight_reg[0] <= bnc_pkg::WEIGHT_ROUND_RST;
            weight_reg[1] <= bnc_pkg::WEIGHT_SQUARE_RST;
            weight_reg[2] <= bnc_pkg::WEIGHT_CURLY_RST;
            weight_reg[3] <= bnc_pkg::WEIGHT_ANGLE_RST;
        end
        else
        begin
            depth_reg     <= depth_next;
            fail_reg      <= fail_next;
            fail_pts_reg  <= fail_pts_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    bnc_pkg::REG_WEIGHT_ROUND:  weight_reg[0] <= cfg_data;
                    bnc_pkg::REG_WEIGHT_SQUARE: weight_reg[1] <= cfg_data;
                    bnc_pkg::REG_WEIGHT_CURLY:  weight_reg[2] <= cfg_data;
                    bnc_pkg::REG_WEIGHT_ANGLE:  weight_reg[3] <= cfg_data;
                    default:                    weight_reg[0] <= weight_reg[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
            kind_reg <= cls.kind;
        if (cmd.eol_start)
        begin
            score_reg <= '0;
            idx_reg   <= depth_dec[AW-1:0];
        end
        if (cmd.walk_step)
        begin
            score_reg <= score_step;
            idx_reg   <= idx_reg - AW'(1);
        end
        if (cmd.finish)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `BNC_ASSERT_NEXT(a_finish_clears_line, cmd.finish, out_valid_reg && depth_reg == '0 && fail_reg == bnc_pkg::FAIL_NONE, "line state not cleared after result")
    `BNC_ASSERT_NOW(a_push_has_room, cmd.push, depth_reg < DEPTH_MAX, "push onto full stack")

endmodule

// ===== rtl/bracket_nesting_checker.sv =====
// Top level of the bracket nesting checker: controller plus datapath.
// Depends on bnc_pkg, bnc_ctrl and bnc_datapath.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    in_data   (bnc_pkg::in_item_t)
//   out       source     out_valid / out_ready  out_data  (bnc_pkg::out_item_t)
//   cfg       sink       cfg_wr_en              cfg_index, cfg_data
//
// A character is taken in the idle state; a closing bracket that pops the stack
// also passes through S_POP (registered stack read before the compare). An end
// of line goes to S_FIN for an empty or failed line, else through the score walk,
// one stack entry per cycle. Reset is asynchronous and needs no clearing pass.
// A waiting result holds the output register; characters are still taken,
// and the next end of line waits for the register to drain.
module bracket_nesting_checker #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [bnc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bnc_pkg::WEIGHT_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bnc_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bnc_pkg::out_item_t              out_data
);

    bnc_pkg::dp_cmd_t    cmd;
    bnc_pkg::dp_status_t st;

    bnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    bnc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== bench/bracket_nesting_checker_tb.sv =====
// Self-checking bench for bracket_nesting_checker: drives character and end-of-line
// transactions, predicts each line result and compares it field by field.
// Depends on bnc_pkg and the bracket_nesting_checker RTL.
`timescale 1ns / 1ps

module bracket_nesting_checker_tb;

    localparam int STACK_DEPTH    = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 160;
    localparam logic [bnc_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [bnc_pkg::CFG_INDEX_W-1:0] WEIGHT_REGS [4] =
        '{bnc_pkg::REG_WEIGHT_ROUND, bnc_pkg::REG_WEIGHT_SQUARE,
          bnc_pkg::REG_WEIGHT_CURLY, bnc_pkg::REG_WEIGHT_ANGLE};

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [bnc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bnc_pkg::WEIGHT_W-1:0]    cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    bnc_pkg::in_item_t               in_data;
    logic                            out_valid;
    logic                            out_ready;
    bnc_pkg::out_item_t              out_data;

    logic [bnc_pkg::WEIGHT_W-1:0] weight_copy [4] =
        '{bnc_pkg::WEIGHT_ROUND_RST, bnc_pkg::WEIGHT_SQUARE_RST,
          bnc_pkg::WEIGHT_CURLY_RST, bnc_pkg::WEIGHT_ANGLE_RST};
    logic [1:0]                   open_stack [STACK_DEPTH];
    int                           open_depth   = 0;
    logic [1:0]                   line_fault   = bnc_pkg::FAIL_NONE;
    logic [bnc_pkg::WEIGHT_W-1:0] fault_points = '0;
    logic [bnc_pkg::TOTAL_W-1:0]  points_total = '0;
    bnc_pkg::out_item_t           pending_lines [$];

    int error_count    = 0;
    int useful_items   = 0;
    int quiet_cycles   = 0;
    int ready_hold     = 0;
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;

    bracket_nesting_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_idle_cycles();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] opener_char(input logic [1:0] kind);
        case (kind)
            bnc_pkg::KIND_ROUND:  return bnc_pkg::CH_ROUND_OPEN;
            bnc_pkg::KIND_SQUARE: return bnc_pkg::CH_SQUARE_OPEN;
            bnc_pkg::KIND_CURLY:  return bnc_pkg::CH_CURLY_OPEN;
            default:              return bnc_pkg::CH_ANGLE_OPEN;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input logic [1:0] kind);
        case (kind)
            bnc_pkg::KIND_ROUND:  return bnc_pkg::CH_ROUND_CLOSE;
            bnc_pkg::KIND_SQUARE: return bnc_pkg::CH_SQUARE_CLOSE;
            bnc_pkg::KIND_CURLY:  return bnc_pkg::CH_CURLY_CLOSE;
            default:              return bnc_pkg::CH_ANGLE_CLOSE;
        endcase
    endfunction

    function automatic logic [bnc_pkg::WEIGHT_W-1:0] random_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        if (r < 40)
            return '1;
        return bnc_pkg::WEIGHT_W'($urandom_range(0, 65535));
    endfunction

    task automatic advance_line_state(input bnc_pkg::in_item_t item);
        bnc_pkg::out_item_t           line;
        logic [bnc_pkg::WEIGHT_W-1:0] pts;
        logic [bnc_pkg::SCORE_W-1:0]  score;
        int                           ko;
        int                           kc;
        if (item.operation == bnc_pkg::OP_CHAR)
        begin
            if (line_fault != bnc_pkg::FAIL_NONE)
                return;
            useful_items++;
            ko = -1;
            kc = -1;
            for (int k = 0; k < 4; k++)
            begin
                if (item.char_code == opener_char(2'(k)))
                    ko = k;
                if (item.char_code == closer_char(2'(k)))
                    kc = k;
            end
            if (ko >= 0)
            begin
                if (open_depth >= STACK_DEPTH)
                begin
                    line_fault   = bnc_pkg::FAIL_OVERFLOW;
                    fault_points = '0;
                end
                else
                begin
                    open_stack[open_depth] = 2'(ko);
                    open_depth++;
                end
            end
            else if (kc >= 0 && open_depth > 0)
            begin
                open_depth--;
                if (open_stack[open_depth] != 2'(kc))
                begin
                    line_fault   = bnc_pkg::FAIL_CORRUPT;
                    fault_points = weight_copy[kc];
                end
            end
            else
            begin
                line_fault   = bnc_pkg::FAIL_CORRUPT;
                fault_points = '0;
            end
        end
        else
        begin
            useful_items++;
            pts   = '0;
            score = '0;
            if (line_fault != bnc_pkg::FAIL_NONE)
            begin
                line.line_status = line_fault;
                pts              = fault_points;
            end
            else
            begin
                line.line_status = (open_depth == 0) ? bnc_pkg::LINE_BALANCED
                                                     : bnc_pkg::LINE_INCOMPLETE;
                for (int i = open_depth - 1; i >= 0; i--)
                    score = score * 64'd5 + bnc_pkg::SCORE_W'(open_stack[i]) + 64'd1;
            end
            if (bnc_pkg::TOTAL_W'(pts) > TOTAL_MAX - points_total)
                points_total = TOTAL_MAX;
            else
                points_total = points_total + bnc_pkg::TOTAL_W'(pts);
            line.line_points      = pts;
            line.completion_score = score;
            line.error_total      = points_total;
            pending_lines.push_back(line);
            open_depth   = 0;
            line_fault   = bnc_pkg::FAIL_NONE;
            fault_points = '0;
        end
    endtask

    // Leave valid high after a transaction; the next call either replaces the payload or drops it.
    task automatic send_item(input logic op, input logic [7:0] code);
        bnc_pkg::in_item_t item;
        int                gap;
        item.operation = op;
        item.char_code = code;
        gap = 0;
        if (sender_idles && $urandom_range(0, 99) < 25)
            gap = pick_idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        advance_line_state(item);
    endtask

    task automatic send_line(input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(bnc_pkg::OP_CHAR, text[i]);
        send_item(bnc_pkg::OP_EOL, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_line();
        logic [1:0] open_kinds [$];
        logic [1:0] kind;
        int         steps;
        int         r;
        steps = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 14);
        for (int i = 0; i < steps; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(bnc_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
            else if (r < 6)
                send_item(bnc_pkg::OP_CHAR, closer_char(2'($urandom)));
            else if (open_kinds.size() == 0 || r < 55)
            begin
                kind = 2'($urandom);
                open_kinds.push_back(kind);
                send_item(bnc_pkg::OP_CHAR, opener_char(kind));
            end
            else
                send_item(bnc_pkg::OP_CHAR, closer_char(open_kinds.pop_back()));
        end
        if ($urandom_range(0, 1) == 1)
            while (open_kinds.size() > 0)
                send_item(bnc_pkg::OP_CHAR, closer_char(open_kinds.pop_back()));
        send_item(bnc_pkg::OP_EOL, 8'($urandom_range(0, 255)));
    endtask

    task automatic await_all_lines();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_weights(input logic [bnc_pkg::WEIGHT_W-1:0] w_round, w_square,
                               w_curly, w_angle);
        logic [bnc_pkg::WEIGHT_W-1:0] w [4];
        w = '{w_round, w_square, w_curly, w_angle};
        await_all_lines();
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_wr_en      <= 1'b1;
            cfg_index      <= WEIGHT_REGS[i];
            cfg_data       <= w[i];
            weight_copy[i] = w[i];
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_mismatch_lines();
        send_line("[)");
        send_line("(]");
        send_line("(}");
        send_line("(>");
    endtask

    task automatic test_reset_weights();
        send_item(bnc_pkg::OP_EOL, 8'h00);
        send_line("()");
        send_line("([{<");
        send_mismatch_lines();
        send_line(")");
        send_item(bnc_pkg::OP_CHAR, 8'h00);
        send_item(bnc_pkg::OP_EOL, 8'hFF);
        send_item(bnc_pkg::OP_CHAR, 8'hFF);
        send_line("(");
        send_line("<a((");
        send_line("{[]}<>");
    endtask

    task automatic test_weight_extremes();
        set_weights('0, '0, '0, '0);
        send_mismatch_lines();
        set_weights('1, '1, '1, '1);
        send_mismatch_lines();
        set_weights(16'h8000, 16'h0001, 16'h7FFF, 16'hAAAA);
        send_mismatch_lines();
    endtask

    task automatic test_stack_limits();
        logic [1:0] open_kinds [$];
        logic [1:0] kind;
        set_weights(random_weight(), random_weight(), random_weight(), random_weight());
        for (int i = 0; i < STACK_DEPTH; i++)
            send_item(bnc_pkg::OP_CHAR, opener_char(2'($urandom)));
        send_item(bnc_pkg::OP_EOL, 8'($urandom_range(0, 255)));
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            kind = 2'($urandom);
            open_kinds.push_back(kind);
            send_item(bnc_pkg::OP_CHAR, opener_char(kind));
        end
        while (open_kinds.size() > 0)
            send_item(bnc_pkg::OP_CHAR, closer_char(open_kinds.pop_back()));
        send_item(bnc_pkg::OP_EOL, 8'($urandom_range(0, 255)));
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_item(bnc_pkg::OP_CHAR, opener_char(2'($urandom)));
        send_line(")");
        for (int i = 0; i < STACK_DEPTH; i++)
            send_item(bnc_pkg::OP_CHAR, opener_char(bnc_pkg::KIND_ROUND));
        send_line("]");
        send_line("(");
    endtask

    task automatic test_backpressure();
        ready_hold = 400;
        repeat (6) send_random_line();
        await_all_lines();
        repeat (3) send_random_line();
        await_all_lines();
    endtask

    task automatic test_random_traffic();
        int phase_end;
        phase_end = useful_items;
        for (int phase = 0; phase < 8; phase++)
        begin
            set_weights(random_weight(), random_weight(), random_weight(), random_weight());
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            phase_end      = phase_end + RANDOM_ITEMS / 8;
            while (useful_items < phase_end)
                send_random_line();
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                out_ready <= 1'b0;
                ready_hold--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (receiver_idles && $urandom_range(0, 99) < 20)
            begin
                out_ready  <= 1'b0;
                stall_left = pick_idle_cycles() - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic report_field(input string name, input logic [63:0] want, got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        bnc_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lines.size() == 0)
            begin
                $display("%0t ns: unexpected line result, expected none, actual %h",
                         $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_lines.pop_front();
                report_field("line_status", want.line_status, out_data.line_status);
                report_field("line_points", want.line_points, out_data.line_points);
                report_field("completion_score", want.completion_score,
                             out_data.completion_score);
                report_field("error_total", want.error_total, out_data.error_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = bnc_pkg::REG_WEIGHT_ROUND;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_weights();
        test_weight_extremes();
        test_stack_limits();
        test_backpressure();
        test_random_traffic();
        await_all_lines();
        repeat (300) @(posedge clk);
        if (error_count == 0 && pending_lines.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
